/* src/byte_stuffed_frame_deframer_macros.svh */
// Assertion helpers shared by the deframer modules.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BYTE_STUFFED_FRAME_DEFRAMER_MACROS_SVH
`define BYTE_STUFFED_FRAME_DEFRAMER_MACROS_SVH

// The expression holds at every sampled edge.
`define BSFD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define BSFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define BSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bsfd_pkg.sv */
// ----------------------------------------------------------------------------
// bsfd_pkg
// Types and constants shared by the byte-stuffed frame deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsfd_pkg;

    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_START_DELIMITER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_DELIMITER   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CODE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 3'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_START_DELIMITER = 8'hCA;
    localparam logic [7:0] RST_END_DELIMITER   = 8'hAC;
    localparam logic [7:0] RST_ESCAPE_CODE     = 8'hAA;
    localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'h01;

    // Escape suffixes.
    localparam logic [7:0] SUFFIX_START  = 8'h35;
    localparam logic [7:0] SUFFIX_END    = 8'h53;
    localparam logic [7:0] SUFFIX_ESCAPE = 8'h55;

    // Result kinds.
    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_RAW_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_DELIMITER = 3'd2;
    localparam logic [2:0] ST_PAYLOAD_SHORT = 3'd3;
    localparam logic [2:0] ST_CHECKSUM      = 3'd4;
    localparam logic [2:0] ST_ADDRESS       = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } in_beat_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       run_last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] start_delimiter;
        logic [7:0] end_delimiter;
        logic [7:0] escape_code;
        logic [7:0] device_address;
    } cfg_regs_t;

    typedef struct packed {
        logic [2:0] raw_position;
        logic       start_matched;
        logic       escape_pending;
        logic [7:0] held_byte;
        logic [1:0] decoded_count;
        logic [7:0] running_sum;
        logic [7:0] address_seen;
        logic [7:0] command_seen;
    } frame_state_t;

    // Outcome of pushing one decoded byte through the hold stage.
    typedef struct packed {
        frame_state_t state;
        logic         emit;
        logic [7:0]   data;
    } push_t;

endpackage

/* src/bsfd_core.sv */
// ----------------------------------------------------------------------------
// bsfd_core
// Frame state register and the single-pass decode of one raw byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_stuffed_frame_deframer_macros.svh"

module bsfd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsfd_pkg::cfg_regs_t  cfg,
    input  logic                 fire,
    input  bsfd_pkg::in_beat_t   item,
    output bsfd_pkg::out_beat_t  res0,
    output bsfd_pkg::out_beat_t  res1,
    output logic [1:0]           res_count
);

    bsfd_pkg::frame_state_t state_reg;
    bsfd_pkg::frame_state_t state_next;
    bsfd_pkg::frame_state_t pre_status;
    bsfd_pkg::push_t        p1;
    bsfd_pkg::push_t        p2;
    bsfd_pkg::out_beat_t    a_beat;
    bsfd_pkg::out_beat_t    b_beat;
    logic                   a_valid;
    logic                   b_valid;
    logic                   use1;
    logic                   use2;
    logic                   dbl;
    logic [7:0]             dec1;
    logic [2:0]             st_code;

    // The decoded byte enters the hold; the byte it displaces is either the
    // address, the command or a parameter, and always joins the sum.
    function automatic bsfd_pkg::push_t push(bsfd_pkg::frame_state_t s, logic [7:0] d);
        bsfd_pkg::push_t r;
        r       = '0;
        r.state = s;
        r.emit  = (s.decoded_count == 2'd3);
        r.data  = s.held_byte;
        if (s.decoded_count == 2'd1) begin
            r.state.address_seen = s.held_byte;
        end
        if (s.decoded_count == 2'd2) begin
            r.state.command_seen = s.held_byte;
        end
        if (s.decoded_count != 2'd0) begin
            r.state.running_sum = s.running_sum + s.held_byte;
        end
        r.state.held_byte = d;
        if (s.decoded_count != 2'd3) begin
            r.state.decoded_count = s.decoded_count + 2'd1;
        end
        return r;
    endfunction

    function automatic bsfd_pkg::out_beat_t make_beat(logic kind, logic [7:0] data,
                                                      logic [2:0] st);
        bsfd_pkg::out_beat_t r;
        r.result_kind = kind;
        r.data_byte   = data;
        r.status      = st;
        r.run_last    = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        pre_status = state_reg;
        p1         = '0;
        p2         = '0;
        use1       = 1'b0;
        use2       = 1'b0;
        dbl        = 1'b0;
        dec1       = cfg.escape_code;
        st_code    = bsfd_pkg::ST_OK;
        a_valid    = 1'b0;
        b_valid    = 1'b0;
        a_beat     = '0;
        b_beat     = '0;

        if (!item.frame_last)
        begin
            if (state_reg.raw_position == 3'd0)
            begin
                state_next.start_matched = (item.rx_byte == cfg.start_delimiter);
            end
            else if (state_reg.escape_pending)
            begin
                state_next.escape_pending = 1'b0;
                case (item.rx_byte)
                    bsfd_pkg::SUFFIX_START:  dec1 = cfg.start_delimiter;
                    bsfd_pkg::SUFFIX_END:    dec1 = cfg.end_delimiter;
                    bsfd_pkg::SUFFIX_ESCAPE: dec1 = cfg.escape_code;
                    default:
                    begin
                        dec1 = cfg.escape_code;
                        dbl  = 1'b1;
                    end
                endcase
                p1         = push(state_next, dec1);
                use1       = 1'b1;
                state_next = p1.state;
                if (dbl)
                begin
                    p2         = push(state_next, item.rx_byte);
                    use2       = 1'b1;
                    state_next = p2.state;
                end
            end
            else if (item.rx_byte == cfg.escape_code)
            begin
                state_next.escape_pending = 1'b1;
            end
            else
            begin
                p1         = push(state_next, item.rx_byte);
                use1       = 1'b1;
                state_next = p1.state;
            end

            if (state_reg.raw_position != 3'd7)
            begin
                state_next.raw_position = state_reg.raw_position + 3'd1;
            end

            a_valid = use1 && p1.emit;
            a_beat  = make_beat(bsfd_pkg::KIND_PARAM, p1.data, bsfd_pkg::ST_OK);
            b_valid = use2 && p2.emit;
            b_beat  = make_beat(bsfd_pkg::KIND_PARAM, p2.data, bsfd_pkg::ST_OK);
        end
        else
        begin
            // A dangling escape at the end of the payload is decoded raw.
            if ((state_reg.raw_position != 3'd0) && state_reg.escape_pending)
            begin
                state_next.escape_pending = 1'b0;
                p1         = push(state_next, cfg.escape_code);
                use1       = 1'b1;
                pre_status = p1.state;
            end

            if (state_reg.raw_position < 3'd4)
                st_code = bsfd_pkg::ST_RAW_SHORT;
            else if (!state_reg.start_matched || (item.rx_byte != cfg.end_delimiter))
                st_code = bsfd_pkg::ST_BAD_DELIMITER;
            else if (pre_status.decoded_count != 2'd3)
                st_code = bsfd_pkg::ST_PAYLOAD_SHORT;
            else if (~pre_status.running_sum != pre_status.held_byte)
                st_code = bsfd_pkg::ST_CHECKSUM;
            else if (pre_status.address_seen != cfg.device_address)
                st_code = bsfd_pkg::ST_ADDRESS;
            else
                st_code = bsfd_pkg::ST_OK;

            a_valid    = use1 && p1.emit;
            a_beat     = make_beat(bsfd_pkg::KIND_PARAM, p1.data, bsfd_pkg::ST_OK);
            b_valid    = 1'b1;
            b_beat     = make_beat(bsfd_pkg::KIND_STATUS, pre_status.command_seen, st_code);
            state_next = '0;
        end
    end

    // Pack the up to two results in order; the final one carries run_last.
    always_comb
    begin
        res0          = a_valid ? a_beat : b_beat;
        res0.run_last = !(a_valid && b_valid);
        res1          = b_beat;
        res1.run_last = 1'b1;
        res_count     = {1'b0, a_valid} + {1'b0, b_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    `BSFD_ASSERT_NEXT(a_core_clear_after_last, fire && item.frame_last, (state_reg.raw_position == 3'd0) && !state_reg.escape_pending && (state_reg.decoded_count == 2'd0), "frame state not cleared after final byte")
    `BSFD_ASSERT_SAME(a_core_first_silent, fire && !item.frame_last && (state_reg.raw_position == 3'd0), res_count == 2'd0, "first raw byte produced a result")

endmodule

/* src/bsfd_result_fifo.sv */
// ----------------------------------------------------------------------------
// bsfd_result_fifo
// Small result queue that takes up to two beats a cycle and gives one while the reader is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_stuffed_frame_deframer_macros.svh"

module bsfd_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  bsfd_pkg::out_beat_t  push_data0,
    input  bsfd_pkg::out_beat_t  push_data1,
    output logic                 space_ok,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bsfd_pkg::out_beat_t  res_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsfd_pkg::out_beat_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign res_valid    = (count_reg != '0);
    assign res_data     = entries[rd_ptr_reg];
    assign pop          = res_valid && res_ready;
    assign space_ok     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wrap_inc(wr_ptr_reg);

    always_comb
    begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            entries[wr_ptr_plus1] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BSFD_ASSERT_ALWAYS(a_fifo_bounded, count_reg <= CNT_W'(DEPTH), "result queue overflow")
    `BSFD_ASSERT_SAME(a_fifo_push_room, push_count != 2'd0, count_reg <= CNT_W'(DEPTH - 2), "results pushed without room for two")

endmodule

/* src/byte_stuffed_frame_deframer.sv */
// Path: a raw byte accepted into the input register is decoded once the queue has room
// for its results, which are written into the result queue and offered from there.
// Throughput: one raw byte per cycle while the queue has room for two results, limited
// by the single decode pass; a byte with two results offers both in turn via the queue.
// Reset: rst_n clears the frame state, the queue and the input register at once and
// loads the configuration registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer
// Deframer for byte-stuffed frames with delimiter, address and inverted-sum checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_stuffed_frame_deframer_macros.svh"

module byte_stuffed_frame_deframer #(
    parameter int RESULT_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Raw byte channel.
    input  logic                               rx_valid,
    output logic                               rx_ready,
    input  bsfd_pkg::in_beat_t                 rx_data,
    // Result channel.
    output logic                               res_valid,
    input  logic                               res_ready,
    output bsfd_pkg::out_beat_t                res_data,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);

    // The configuration registers. A write to an index beyond the four
    // registers is accepted and has no effect.
    bsfd_pkg::cfg_regs_t cfg_reg;
    bsfd_pkg::cfg_regs_t cfg_next;

    // Input register: each accepted beat waits here for one decode pass. It
    // refills in the same cycle that it drains, so beats can arrive back to back.
    logic                rx_full_reg;
    logic                rx_full_next;
    bsfd_pkg::in_beat_t  rx_hold_reg;

    logic                core_fire;
    logic                space_ok;
    logic [1:0]          res_count;
    logic [1:0]          push_count;
    bsfd_pkg::out_beat_t res0;
    bsfd_pkg::out_beat_t res1;

    // The decode pass runs only when the queue has room for the two results
    // that one byte may cause; that check uses the registered fill level only.
    assign core_fire  = rx_full_reg && space_ok;
    assign rx_ready   = !rx_full_reg || core_fire;
    assign cfg_ready  = 1'b1;
    assign push_count = core_fire ? res_count : 2'd0;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bsfd_pkg::REG_START_DELIMITER: cfg_next.start_delimiter = cfg_data;
                bsfd_pkg::REG_END_DELIMITER:   cfg_next.end_delimiter   = cfg_data;
                bsfd_pkg::REG_ESCAPE_CODE:     cfg_next.escape_code     = cfg_data;
                bsfd_pkg::REG_DEVICE_ADDRESS:  cfg_next.device_address  = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end

        if (rx_valid && rx_ready)
            rx_full_next = 1'b1;
        else if (core_fire)
            rx_full_next = 1'b0;
        else
            rx_full_next = rx_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delimiter <= bsfd_pkg::RST_START_DELIMITER;
            cfg_reg.end_delimiter   <= bsfd_pkg::RST_END_DELIMITER;
            cfg_reg.escape_code     <= bsfd_pkg::RST_ESCAPE_CODE;
            cfg_reg.device_address  <= bsfd_pkg::RST_DEVICE_ADDRESS;
            rx_full_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            rx_full_reg <= rx_full_next;
        end
    end

    // The held beat is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            rx_hold_reg <= rx_data;
        end
    end

    bsfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (core_fire),
        .item      (rx_hold_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    bsfd_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data0 (res0),
        .push_data1 (res1),
        .space_ok   (space_ok),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    // A beat that cannot be decoded for lack of queue room must stay put.
    `BSFD_ASSERT_NEXT(a_top_hold_stalled, rx_full_reg && !space_ok, rx_full_reg && $stable(rx_hold_reg), "stalled input beat lost or changed")

endmodule
